FILE: rtl/mwct_pkg.sv
package mwct_pkg;

   // Table size and the widths that follow from it.
   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Field widths of the request and response channels.
   localparam int ADDR_W   = 32;
   localparam int DATA_W   = 32;
   localparam int KIND_W   = 4;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;

   localparam int REQ_TDATA_W = 200;
   localparam int RSP_TDATA_W = 40;

   // Request opcodes, carried on req_tuser.
   typedef enum logic [OP_W-1:0] {
      REQ_ADD         = 3'd0,
      REQ_REMOVE      = 3'd1,
      REQ_CLEAR       = 3'd2,
      REQ_CHECK_WRITE = 3'd3,
      REQ_CHECK_RANGE = 3'd4,
      REQ_CHECK_ALL   = 3'd5
   } req_op_type;

   // Comparison kinds stored with each watch condition.
   typedef enum logic [KIND_W-1:0] {
      KIND_EQ      = 4'd0,
      KIND_NE      = 4'd1,
      KIND_LT      = 4'd2,
      KIND_GT      = 4'd3,
      KIND_LE      = 4'd4,
      KIND_GE      = 4'd5,
      KIND_ALLSET  = 4'd6,
      KIND_ANYSET  = 4'd7,
      KIND_NONESET = 4'd8,
      KIND_INSIDE  = 4'd9,
      KIND_OUTSIDE = 4'd10
   } kind_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_FULL = 2'd1,
      STATUS_MISS = 2'd2
   } status_type;

   // One watch condition as held in the table.
   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] ref_value;
      logic [DATA_W-1:0] test_mask;
      logic [DATA_W-1:0] low_bound;
      logic [DATA_W-1:0] high_bound;
      logic [KIND_W-1:0] kind_code;
      logic              is_active;
   } entry_type;

endpackage

FILE: rtl/mwct_eval.sv
module mwct_eval (
   input  mwct_pkg::entry_type             entry,
   input  logic [mwct_pkg::DATA_W-1:0]     test_value,
   output logic                            passed
);
   import mwct_pkg::*;

   logic [DATA_W-1:0] masked;

   assign masked = test_value & entry.test_mask;

   // Compare the tested value against one stored condition.
   always_comb begin
      unique case (entry.kind_code)
         KIND_EQ:      passed = (test_value == entry.ref_value);
         KIND_NE:      passed = (test_value != entry.ref_value);
         KIND_LT:      passed = (test_value <  entry.ref_value);
         KIND_GT:      passed = (test_value >  entry.ref_value);
         KIND_LE:      passed = (test_value <= entry.ref_value);
         KIND_GE:      passed = (test_value >= entry.ref_value);
         KIND_ALLSET:  passed = (masked == entry.test_mask);
         KIND_ANYSET:  passed = (masked != '0);
         KIND_NONESET: passed = (masked == '0);
         KIND_INSIDE:  passed = (test_value >= entry.low_bound) &&
                                (test_value <= entry.high_bound);
         KIND_OUTSIDE: passed = (test_value <  entry.low_bound) ||
                                (test_value >  entry.high_bound);
         // Unknown kinds always fail.
         default:      passed = 1'b0;
      endcase
   end

endmodule

FILE: rtl/memory_watch_condition_table_top.sv
// Ordered table of up to sixteen watch conditions held in a single-port-read
// entry memory and walked one entry per clock, unless the response side stalls,
// by a small sequencer that shares one condition evaluator. The block takes one
// request at a time and drops req_tready until that request is finished. A
// check gives one response per tested entry and then a summary. Add and remove
// search the table and then close the gap one entry per cycle; together the
// search and the compaction visit each entry once. The memory gives one read
// per cycle. An add to a full table that does not replace an entry is dropped
// with status "full"; a remove that finds nothing reports "miss".
module memory_watch_condition_table_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // From bit 0: address, range_end, data_value, bit_mask, bound_low,
   // bound_high, compare_kind, enable_flag, zero fill.
   input  logic [mwct_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // req_type.
   input  logic [mwct_pkg::OP_W-1:0]            req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // From bit 0: status, slot, entry_address, entry_passed, overall_pass.
   output logic [mwct_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // is_summary.
   output logic                                 rsp_tuser,
   output logic                                 rsp_tlast
);
   import mwct_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_COMPACT,
      ST_WRITE,
      ST_SCAN,
      ST_SUMMARY
   } state_type;

   // Sequencer state.
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   status_type       status_ff, status_in;
   logic             overall_ff, overall_in;

   // Latched request.
   req_op_type        op_ff;
   entry_type         new_ff;
   logic [ADDR_W-1:0] range_end_ff;

   // Entry memory.
   entry_type        mem [TABLE_DEPTH];
   entry_type        rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   // Response register.
   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic              rsp_summary_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic              rsp_passed_ff;
   logic              rsp_overall_ff;
   logic              rsp_last_ff;

   logic              out_free;
   logic              out_load;
   logic              out_summary;
   logic              out_passed;
   logic              out_overall;

   logic [CNT_W-1:0]  idx_next;
   logic [CNT_W-1:0]  idx_next2;
   logic              req_fire;
   logic [DATA_W-1:0] test_value;
   logic              entry_pass;
   logic              entry_sel;
   logic              in_table;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign idx_next   = idx_ff + CNT_W'(1);
   assign idx_next2  = idx_ff + CNT_W'(2);
   assign in_table   = (idx_ff < count_ff);

   // Shared condition evaluator for the entry being walked.
   assign test_value = (op_ff == REQ_CHECK_WRITE) ? new_ff.ref_value : rd_data_ff.ref_value;

   mwct_eval u_eval (
      .entry      (rd_data_ff),
      .test_value (test_value),
      .passed     (entry_pass)
   );

   // Decide whether the current entry takes part in the check.
   always_comb begin
      case (op_ff)
         REQ_CHECK_WRITE: entry_sel = (rd_data_ff.address == new_ff.address);
         REQ_CHECK_RANGE: entry_sel = (rd_data_ff.address >= new_ff.address) &&
                                      (rd_data_ff.address <= range_end_ff);
         default:         entry_sel = 1'b1;
      endcase
      entry_sel = entry_sel && rd_data_ff.is_active;
   end

   // Sequencer next state, memory access and response selection.
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      overall_in  = overall_ff;
      rd_addr     = idx_ff[IDX_W-1:0];
      wr_en       = 1'b0;
      wr_addr     = idx_ff[IDX_W-1:0];
      wr_data     = rd_data_ff;
      out_load    = 1'b0;
      out_summary = 1'b0;
      out_passed  = 1'b0;
      out_overall = overall_ff;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = '0;
            if (req_tvalid) begin
               idx_in     = '0;
               status_in  = STATUS_OK;
               overall_in = 1'b1;
               case (req_tuser)
                  REQ_ADD, REQ_REMOVE: state_in = ST_FIND;
                  REQ_CLEAR: begin
                     count_in = '0;
                     state_in = ST_SUMMARY;
                  end
                  REQ_CHECK_WRITE, REQ_CHECK_RANGE, REQ_CHECK_ALL: state_in = ST_SCAN;
                  default: state_in = ST_SUMMARY;
               endcase
            end
         end
         ST_FIND: begin
            if (!in_table) begin
               if (op_ff == REQ_ADD) begin
                  if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_SUMMARY;
                  end else begin
                     state_in = ST_WRITE;
                  end
               end else begin
                  status_in = STATUS_MISS;
                  state_in  = ST_SUMMARY;
               end
            end else if (rd_data_ff.address == new_ff.address) begin
               state_in = ST_COMPACT;
               rd_addr  = idx_next[IDX_W-1:0];
            end else begin
               idx_in  = idx_next;
               rd_addr = idx_next[IDX_W-1:0];
            end
         end
         ST_COMPACT: begin
            // Move each later entry down by one until the end of the table.
            if (idx_next >= count_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = (op_ff == REQ_ADD) ? ST_WRITE : ST_SUMMARY;
            end else begin
               wr_en   = 1'b1;
               wr_addr = idx_ff[IDX_W-1:0];
               wr_data = rd_data_ff;
               idx_in  = idx_next;
               rd_addr = idx_next2[IDX_W-1:0];
            end
         end
         ST_WRITE: begin
            wr_en    = 1'b1;
            wr_addr  = count_ff[IDX_W-1:0];
            wr_data  = new_ff;
            count_in = count_ff + CNT_W'(1);
            state_in = ST_SUMMARY;
         end
         ST_SCAN: begin
            if (!in_table) begin
               state_in = ST_SUMMARY;
            end else if (entry_sel && !out_free) begin
               rd_addr = idx_ff[IDX_W-1:0];
            end else begin
               if (entry_sel) begin
                  out_load    = 1'b1;
                  out_passed  = entry_pass;
                  out_overall = overall_ff & entry_pass;
                  overall_in  = overall_ff & entry_pass;
               end
               idx_in  = idx_next;
               rd_addr = idx_next[IDX_W-1:0];
            end
         end
         ST_SUMMARY: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_summary = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer registers and response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         status_ff    <= STATUS_OK;
         overall_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         idx_ff     <= idx_in;
         count_ff   <= count_in;
         status_ff  <= status_in;
         overall_ff <= overall_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff                <= req_op_type'(req_tuser);
         new_ff.address       <= req_tdata[31:0];
         range_end_ff         <= req_tdata[63:32];
         new_ff.ref_value     <= req_tdata[95:64];
         new_ff.test_mask     <= req_tdata[127:96];
         new_ff.low_bound     <= req_tdata[159:128];
         new_ff.high_bound    <= req_tdata[191:160];
         new_ff.kind_code     <= req_tdata[195:192];
         new_ff.is_active     <= req_tdata[196];
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_status_ff  <= out_summary ? status_ff : STATUS_OK;
         rsp_summary_ff <= out_summary;
         rsp_slot_ff    <= out_summary ? '0 : SLOT_W'(idx_ff);
         rsp_addr_ff    <= out_summary ? '0 : rd_data_ff.address;
         rsp_passed_ff  <= out_passed;
         rsp_overall_ff <= out_overall;
         rsp_last_ff    <= out_summary;
      end
   end

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_overall_ff, rsp_passed_ff, rsp_addr_ff, rsp_slot_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_summary_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mwct_pkg::*;

   // Request codes that the block does not define; they must answer with a plain summary.
   localparam logic [OP_W-1:0] OP_RESERVED_A = 3'd6;
   localparam logic [OP_W-1:0] OP_RESERVED_B = 3'd7;

   localparam int POOL_SIZE = 20;
   localparam int PHASE_REQUESTS = 102;
   localparam int MAX_REPORTS = 10;

   // One response as it appears on the result channel.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                summary;
      logic [SLOT_W-1:0]   slot;
      logic [ADDR_W-1:0]   address;
      logic                passed;
      logic                overall;
      logic                tlast;
   } watch_result_type;

   // Shadow copy of the condition table that predicts and checks every response.
   class watch_table_tracker_type;
      entry_type        conditions[TABLE_DEPTH];
      int               used;
      watch_result_type awaited[$];
      int               error_count;

      function int pending();
         return awaited.size();
      endfunction

      function void push_summary(status_type st, logic overall);
         watch_result_type r;
         r = '0;
         r.status = st;
         r.summary = 1'b1;
         r.overall = overall;
         r.tlast = 1'b1;
         awaited = {awaited, r};
      endfunction

      // Evaluates one stored condition against a tested value, unsigned.
      function logic holds(entry_type e, logic [DATA_W-1:0] v);
         case (e.kind_code)
            KIND_EQ:      return v == e.ref_value;
            KIND_NE:      return v != e.ref_value;
            KIND_LT:      return v < e.ref_value;
            KIND_GT:      return v > e.ref_value;
            KIND_LE:      return v <= e.ref_value;
            KIND_GE:      return v >= e.ref_value;
            KIND_ALLSET:  return (v & e.test_mask) == e.test_mask;
            KIND_ANYSET:  return (v & e.test_mask) != '0;
            KIND_NONESET: return (v & e.test_mask) == '0;
            KIND_INSIDE:  return v >= e.low_bound && v <= e.high_bound;
            KIND_OUTSIDE: return v < e.low_bound || v > e.high_bound;
            default:      return 1'b0;
         endcase
      endfunction

      // Deletes one entry and closes the gap behind it.
      function void drop_at(int idx);
         for (int j = idx; j < used - 1; j++) begin
            conditions[j] = conditions[j + 1];
         end
         used--;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [REQ_TDATA_W-1:0] payload);
         logic [ADDR_W-1:0] addr;
         logic [ADDR_W-1:0] rend;
         logic [DATA_W-1:0] value;
         entry_type         fresh;
         int                hit;
         logic              overall;
         logic              sel;
         logic              ok;
         watch_result_type  r;
         addr = payload[31:0];
         rend = payload[63:32];
         value = payload[95:64];
         fresh.address = addr;
         fresh.ref_value = value;
         fresh.test_mask = payload[127:96];
         fresh.low_bound = payload[159:128];
         fresh.high_bound = payload[191:160];
         fresh.kind_code = payload[195:192];
         fresh.is_active = payload[196];

         // The table never holds an address twice, so the first match is the only one.
         hit = -1;
         for (int i = 0; i < used; i++) begin
            if (hit < 0 && conditions[i].address == addr) hit = i;
         end

         case (op)
            REQ_ADD: begin
               if (hit < 0 && used >= TABLE_DEPTH) begin
                  push_summary(STATUS_FULL, 1'b1);
               end else begin
                  if (hit >= 0) drop_at(hit);
                  conditions[used] = fresh;
                  used++;
                  push_summary(STATUS_OK, 1'b1);
               end
            end
            REQ_REMOVE: begin
               if (hit >= 0) begin
                  drop_at(hit);
                  push_summary(STATUS_OK, 1'b1);
               end else begin
                  push_summary(STATUS_MISS, 1'b1);
               end
            end
            REQ_CLEAR: begin
               used = 0;
               push_summary(STATUS_OK, 1'b1);
            end
            REQ_CHECK_WRITE, REQ_CHECK_RANGE, REQ_CHECK_ALL: begin
               overall = 1'b1;
               for (int i = 0; i < used; i++) begin
                  if (op == REQ_CHECK_WRITE) begin
                     sel = conditions[i].address == addr;
                  end else if (op == REQ_CHECK_RANGE) begin
                     sel = conditions[i].address >= addr && conditions[i].address <= rend;
                  end else begin
                     sel = 1'b1;
                  end
                  if (conditions[i].is_active && sel) begin
                     ok = holds(conditions[i],
                                (op == REQ_CHECK_WRITE) ? value : conditions[i].ref_value);
                     if (!ok) overall = 1'b0;
                     r = '0;
                     r.status = STATUS_OK;
                     r.slot = i[SLOT_W-1:0];
                     r.address = conditions[i].address;
                     r.passed = ok;
                     r.overall = overall;
                     awaited = {awaited, r};
                  end
               end
               push_summary(STATUS_OK, overall);
            end
            default: begin
               push_summary(STATUS_OK, 1'b1);
            end
         endcase
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] data, logic user, logic tlast);
         watch_result_type got;
         watch_result_type want;
         got.status = data[1:0];
         got.slot = data[5:2];
         got.address = data[37:6];
         got.passed = data[38];
         got.overall = data[39];
         got.summary = user;
         got.tlast = tlast;
         if (awaited.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("unexpected response: st %0d sum %b slot %0d addr %h pass %b ovr %b last %b",
                        got.status, got.summary, got.slot, got.address,
                        got.passed, got.overall, got.tlast);
            end
         end else begin
            want = awaited.pop_front();
            if (got !== want) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("response mismatch: expected st %0d sum %b slot %0d addr %h pass %b ovr %b last %b",
                           want.status, want.summary, want.slot, want.address,
                           want.passed, want.overall, want.tlast);
                  $display("                   actual   st %0d sum %b slot %0d addr %h pass %b ovr %b last %b",
                           got.status, got.summary, got.slot, got.address,
                           got.passed, got.overall, got.tlast);
               end
            end
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]        req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   rsp_tlast;

   watch_table_tracker_type tracker;
   logic [ADDR_W-1:0]       addr_pool[POOL_SIZE];
   int                      req_idle_pct = 36;
   int                      rsp_idle_pct = 45;

   memory_watch_condition_table_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #10 clock = ~clock;

   // Result side: check each accepted response, then pick the next ready value.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_response(rsp_tdata, rsp_tuser, rsp_tlast);
      end
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // Presents one request after a random gap and holds it until it is taken.
   task automatic send(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                       input logic [ADDR_W-1:0] rend, input logic [DATA_W-1:0] value,
                       input logic [DATA_W-1:0] mask, input logic [DATA_W-1:0] lo,
                       input logic [DATA_W-1:0] hi, input logic [KIND_W-1:0] kind,
                       input logic en);
      logic [REQ_TDATA_W-1:0] payload;
      payload = {3'b000, en, kind, hi, lo, mask, value, rend, addr};
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= payload;
      do @(posedge clock); while (!req_tready);
      tracker.note_request(op, payload);
   endtask

   // Holds off new requests until every outstanding response has come back.
   task automatic hold_until_drained();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   // Mostly addresses from a small pool, so adds collide, removes hit and the table fills.
   function automatic logic [ADDR_W-1:0] pick_addr();
      if ($urandom_range(0, 6) == 0) return pick_word();
      return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
   endfunction

   task automatic send_random();
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      logic [ADDR_W-1:0] rend;
      logic [ADDR_W-1:0] swap;
      logic [DATA_W-1:0] lo;
      logic [DATA_W-1:0] hi;
      logic [KIND_W-1:0] kind;
      int                r;
      r = $urandom_range(0, 99);
      if (r < 40) op = REQ_ADD;
      else if (r < 52) op = REQ_REMOVE;
      else if (r < 55) op = REQ_CLEAR;
      else if (r < 70) op = REQ_CHECK_WRITE;
      else if (r < 82) op = REQ_CHECK_RANGE;
      else if (r < 96) op = REQ_CHECK_ALL;
      else op = $urandom_range(0, 1) ? OP_RESERVED_A : OP_RESERVED_B;

      addr = pick_addr();
      rend = pick_addr();
      // Ranges are mostly well ordered; some are left inverted and test nothing.
      if (addr > rend && $urandom_range(0, 4) != 0) begin
         swap = addr;
         addr = rend;
         rend = swap;
      end
      lo = pick_word();
      hi = pick_word();
      if (lo > hi && $urandom_range(0, 3) != 0) begin
         swap = lo;
         lo = hi;
         hi = swap;
      end
      if ($urandom_range(0, 9) == 0) kind = KIND_W'($urandom_range(11, 15));
      else kind = KIND_W'($urandom_range(KIND_EQ, KIND_OUTSIDE));
      send(op, addr, rend, pick_word(), pick_word(), lo, hi, kind,
           $urandom_range(0, 99) < 80);
   endtask

   initial begin
      #(20_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      tracker = new();
      foreach (addr_pool[i]) addr_pool[i] = $urandom;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, one entry per kind plus unknown and inactive ones.
      send(REQ_CHECK_ALL, '0, '1, '0, '0, '0, '0, KIND_EQ, 1'b1);
      send(REQ_REMOVE, addr_pool[0], '0, '0, '0, '0, '0, KIND_EQ, 1'b1);
      for (int k = KIND_EQ; k <= KIND_OUTSIDE; k++) begin
         send(REQ_ADD, addr_pool[k], '0, k[0] ? 32'hFFFF_FFFF : 32'h0000_0000,
              k[1] ? 32'hFFFF_FFFF : 32'h0000_FFFF, k[2] ? 32'h8000_0000 : 32'h0000_0000,
              k[2] ? 32'hFFFF_FFFF : 32'h7FFF_FFFF, k[KIND_W-1:0], 1'b1);
      end
      send(REQ_ADD, addr_pool[11], '0, $urandom, $urandom, '0, '1, 4'd11, 1'b1);
      send(REQ_ADD, addr_pool[12], '0, $urandom, $urandom, '0, '1, 4'd15, 1'b0);
      send(REQ_CHECK_ALL, '0, '0, '0, '0, '0, '0, KIND_EQ, 1'b0);
      send(REQ_CHECK_WRITE, addr_pool[0], '0, '0, '0, '0, '0, KIND_EQ, 1'b0);
      send(REQ_CHECK_WRITE, addr_pool[9], '0, '1, '0, '0, '0, KIND_EQ, 1'b0);
      send(REQ_CHECK_RANGE, '0, '1, '0, '0, '0, '0, KIND_EQ, 1'b0);
      send(REQ_CHECK_RANGE, 32'd10, 32'd5, '0, '0, '0, '0, KIND_EQ, 1'b0);
      // Re-adding a present address moves it to the end with new contents.
      send(REQ_ADD, addr_pool[3], '0, 32'h1234_5678, '1, '0, '1, KIND_NE, 1'b1);
      send(REQ_REMOVE, addr_pool[5], '0, '0, '0, '0, '0, KIND_EQ, 1'b1);
      send(OP_RESERVED_A, '1, '1, '1, '1, '1, '1, 4'd15, 1'b1);
      send(OP_RESERVED_B, '0, '0, '0, '0, '0, '0, KIND_EQ, 1'b0);
      send(REQ_CLEAR, '0, '0, '0, '0, '0, '0, KIND_EQ, 1'b0);
      send(REQ_CHECK_ALL, '0, '0, '0, '0, '0, '0, KIND_EQ, 1'b0);

      // Random phases: receiver-heavy idling, sender-heavy idling, then none.
      for (int phase = 0; phase < 3; phase++) begin
         hold_until_drained();
         req_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 45 : 0;
         rsp_idle_pct = (phase == 0) ? 45 : (phase == 1) ? 36 : 0;
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if ($urandom_range(0, 39) == 0) hold_until_drained();
            send_random();
         end
      end

      hold_until_drained();
      repeat (40) @(posedge clock);
      if (tracker.error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
